@@ rtl/pwg_pkg.sv @@
// Shared types, register indexes and constants for the waveform generator.
package pwg_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 3'd4;

    // Field widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned AMP_W    = 15;
    localparam int unsigned REG32_W  = 32;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ROM_W    = 16;   // Q1.15 magnitude, 0..32768

    // Register reset values
    localparam logic [AMP_W-1:0]   AMP_RESET   = 15'd4096;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1024;

    // Waveform select; code 3 is unused and yields zero
    typedef enum logic [MODE_W-1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_SAW    = 2'd2
    } wave_mode_t;

    // pi/2 in Q30
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

endpackage

@@ rtl/pwg_quarter_rom.sv @@
// Quarter-wave sine table with registered read and read enable.
module pwg_quarter_rom #(
    parameter int unsigned ADDR_BITS = 10
) (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [ADDR_BITS:0]        rd_addr,   // 0 .. 2^ADDR_BITS inclusive
    output logic [pwg_pkg::ROM_W-1:0] rd_data
);
    import pwg_pkg::*;

    localparam int unsigned DEPTH = (1 << ADDR_BITS) + 1;

    logic [ROM_W-1:0] rom_w [DEPTH];
    logic [ROM_W-1:0] rd_data_reg;

    // Table contents fixed at elaboration: entry i is sin(pi/2 * i / 2^ADDR_BITS)
    // in Q1.15, from a 9-term Taylor series in Q30, rounded half up
    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        localparam logic [63:0] TH = (PI_HALF_Q30 * 64'(i)) >> ADDR_BITS;
        localparam logic [63:0] T1 = ((((TH * TH) >> 30) * TH) >> 30) / 64'd6;
        localparam logic [63:0] T2 = ((((T1 * TH) >> 30) * TH) >> 30) / 64'd20;
        localparam logic [63:0] T3 = ((((T2 * TH) >> 30) * TH) >> 30) / 64'd42;
        localparam logic [63:0] T4 = ((((T3 * TH) >> 30) * TH) >> 30) / 64'd72;
        localparam logic [63:0] T5 = ((((T4 * TH) >> 30) * TH) >> 30) / 64'd110;
        localparam logic [63:0] T6 = ((((T5 * TH) >> 30) * TH) >> 30) / 64'd156;
        localparam logic [63:0] T7 = ((((T6 * TH) >> 30) * TH) >> 30) / 64'd210;
        localparam logic [63:0] T8 = ((((T7 * TH) >> 30) * TH) >> 30) / 64'd272;
        localparam longint SUM = longint'(TH) - longint'(T1) + longint'(T2)
                               - longint'(T3) + longint'(T4) - longint'(T5)
                               + longint'(T6) - longint'(T7) + longint'(T8);
        localparam longint POS = (SUM < 0) ? 64'sd0 : SUM;
        localparam longint VAL = (POS + 64'sd16384) >>> 15;
        localparam logic [ROM_W-1:0] ENTRY = (VAL > 32768) ? ROM_W'(32768) : ROM_W'(VAL);
        assign rom_w[i] = ENTRY;
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom_w[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/periodic_waveform_generator_unit.sv @@
// Top level of the periodic waveform generator: phase accumulator, two-stage sample pipeline.
//
//  Channel  Direction  Payload                                   Transfer
//  s_       in         tdata[0] restart                          tvalid & tready
//  m_       out        tdata[15:0] sample_value,                 tvalid & tready
//                      tdata[31:16] sample_number, tlast = last
//  cfg_     in         cfg_index selects register, cfg_wdata     cfg_wr_en
//
// One sample per clock while m_tready is high; an accepted tick goes through the phase/table
// stage, then the multiply stage, and its sample is held on m_ until taken.
// The table read is the registered stage; amplitude multiply and saturation fill the second.
// Reset (aresetn, synchronous) loads register defaults, index 0 and phase 0; no clearing pass.
// A stalled output holds both stages; s_tready drops only while both stages are full
// and m_tready is low.
module periodic_waveform_generator_unit #(
    parameter int unsigned TABLE_ADDR_BITS = 10,
    parameter int unsigned PHASE_BITS      = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [pwg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pwg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // tick stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [0] restart, [7:1] zero
    // sample stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [15:0] sample_value, [31:16] sample_number
    output logic                            m_tlast    // last
);
    import pwg_pkg::*;

    localparam int unsigned ROM_N = 1 << TABLE_ADDR_BITS;

    // ---------------- configuration registers ----------------
    logic [MODE_W-1:0]  wave_mode_reg;
    logic [AMP_W-1:0]   amplitude_reg;
    logic [REG32_W-1:0] phase_step_reg;
    logic [REG32_W-1:0] phase_offset_reg;
    logic [COUNT_W-1:0] sample_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_mode_reg    <= WAVE_SINE;
            amplitude_reg    <= AMP_RESET;
            phase_step_reg   <= '0;
            phase_offset_reg <= '0;
            sample_count_reg <= COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WAVE_MODE:    wave_mode_reg    <= cfg_wdata[MODE_W-1:0];
                REG_AMPLITUDE:    amplitude_reg    <= cfg_wdata[AMP_W-1:0];
                REG_PHASE_STEP:   phase_step_reg   <= cfg_wdata;
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_wdata;
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- phase alignment ----------------
    logic [PHASE_BITS-1:0] offset_aligned;
    logic [PHASE_BITS-1:0] step_aligned;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [REG32_W-1:0]    p32_cur;

    if (PHASE_BITS >= REG32_W) begin : g_wide_phase
        assign offset_aligned = {phase_offset_reg, {(PHASE_BITS-REG32_W){1'b0}}};
        assign step_aligned   = {phase_step_reg, {(PHASE_BITS-REG32_W){1'b0}}};
        assign p32_cur        = phase_cur[PHASE_BITS-1 -: REG32_W];
    end else begin : g_narrow_phase
        assign offset_aligned = phase_offset_reg[REG32_W-1 -: PHASE_BITS];
        assign step_aligned   = phase_step_reg[REG32_W-1 -: PHASE_BITS];
        assign p32_cur        = {phase_cur, {(REG32_W-PHASE_BITS){1'b0}}};
    end

    // ---------------- handshake ----------------
    logic a_valid_reg;
    logic m_valid_reg;
    logic advance;
    logic s_acc;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- accumulator state and stage A ----------------
    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [COUNT_W-1:0]    sample_index_reg, sample_index_next;
    logic [COUNT_W-1:0]    index_cur;
    logic [COUNT_W-1:0]    last_limit;
    logic                  last_cur;
    logic                  restart;

    assign restart    = s_tdata[0];
    assign phase_cur  = restart ? offset_aligned : phase_acc_reg;
    assign index_cur  = restart ? '0 : sample_index_reg;
    // a count of zero behaves as one
    assign last_limit = (sample_count_reg == '0) ? '0 : sample_count_reg - 1'b1;
    assign last_cur   = index_cur >= last_limit;

    always_comb begin
        if (last_cur) begin
            sample_index_next = '0;
            phase_acc_next    = offset_aligned;
        end else begin
            sample_index_next = index_cur + 1'b1;
            phase_acc_next    = phase_cur + step_aligned;
        end
    end

    // table address: mirror in odd quadrants
    logic [TABLE_ADDR_BITS-1:0] tab_w;
    logic [TABLE_ADDR_BITS:0]   tab_addr;
    assign tab_w    = p32_cur[29 -: TABLE_ADDR_BITS];
    assign tab_addr = p32_cur[30] ? ((TABLE_ADDR_BITS+1)'(ROM_N) - {1'b0, tab_w})
                                  : {1'b0, tab_w};

    logic [REG32_W-1:0] a_p32_reg;
    logic               a_zero_reg;
    logic               a_half_reg;
    logic [COUNT_W-1:0] a_index_reg;
    logic               a_last_reg;
    logic [ROM_W-1:0]   rom_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
            a_valid_reg      <= 1'b0;
        end else begin
            if (s_acc) begin
                phase_acc_reg    <= phase_acc_next;
                sample_index_reg <= sample_index_next;
                a_valid_reg      <= 1'b1;
            end else if (advance) begin
                a_valid_reg      <= 1'b0;
            end
        end
    end

    // stage A payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_p32_reg   <= p32_cur;
            a_zero_reg  <= (phase_cur == '0);
            a_half_reg  <= (phase_cur == {1'b1, {(PHASE_BITS-1){1'b0}}});
            a_index_reg <= index_cur;
            a_last_reg  <= last_cur;
        end
    end

    pwg_quarter_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (tab_addr),
        .rd_data (rom_data)
    );

    // ---------------- stage B: amplitude scaling ----------------
    logic [30:0]                 sin_prod;
    logic [31:0]                 sin_round;
    logic [SAMPLE_W-1:0]         sin_mag;
    logic signed [SAMPLE_W-1:0]  sin_val;
    logic signed [SAMPLE_W-1:0]  amp_s;
    logic signed [REG32_W-1:0]   saw_frac;
    logic signed [47:0]          saw_prod;
    logic signed [47:0]          saw_round;
    logic signed [16:0]          saw_q;
    logic signed [SAMPLE_W-1:0]  saw_val;
    logic signed [SAMPLE_W-1:0]  sq_val;
    logic signed [SAMPLE_W-1:0]  value_next;

    assign amp_s     = signed'({1'b0, amplitude_reg});
    // sine: round(amp * |s| / 2^15), sign from upper half of the turn
    assign sin_prod  = 31'(amplitude_reg) * 31'(rom_data);
    assign sin_round = {1'b0, sin_prod} + 32'd16384;
    assign sin_mag   = sin_round[30:15];
    assign sin_val   = a_p32_reg[31] ? -signed'(sin_mag) : signed'(sin_mag);

    // sawtooth: floor((amp * (p32 - 2^31) + 2^30) / 2^31)
    assign saw_frac  = signed'({~a_p32_reg[31], a_p32_reg[30:0]});
    assign saw_prod  = 48'(amp_s) * 48'(saw_frac);
    assign saw_round = saw_prod + 48'sd1073741824;
    assign saw_q     = saw_round[47:31];

    always_comb begin
        if (saw_q > 17'sd32767) begin
            saw_val = 16'sh7fff;
        end else if (saw_q < -17'sd32768) begin
            saw_val = 16'sh8000;
        end else begin
            saw_val = saw_q[15:0];
        end
    end

    // square: zero exactly at phase zero and half a turn
    always_comb begin
        priority if (a_zero_reg || a_half_reg) begin
            sq_val = '0;
        end else if (a_p32_reg[31]) begin
            sq_val = -amp_s;
        end else begin
            sq_val = amp_s;
        end
    end

    always_comb begin
        unique case (wave_mode_reg)
            WAVE_SINE:   value_next = sin_val;
            WAVE_SQUARE: value_next = sq_val;
            WAVE_SAW:    value_next = saw_val;
            default:     value_next = '0;
        endcase
    end

    // ---------------- output register ----------------
    logic [SAMPLE_W-1:0] m_value_reg;
    logic [COUNT_W-1:0]  m_number_reg;
    logic                m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && a_valid_reg) begin
            m_value_reg  <= value_next;
            m_number_reg <= a_index_reg;
            m_last_reg   <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_number_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    a_wrap_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && last_cur) |=> (sample_index_reg == '0))
        else $error("index did not wrap after last sample");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !last_cur) |=> (sample_index_reg == $past(index_cur) + 1'b1))
        else $error("index did not advance by one");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !advance) |=> (a_valid_reg && $stable(a_index_reg)
                                       && $stable(a_last_reg)))
        else $error("stalled stage A lost its sample");

    a_stage_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && advance) |=> m_valid_reg)
        else $error("sample dropped between stages");

endmodule

@@ bench/periodic_waveform_generator_unit_tb.sv @@
// Self-checking testbench for the periodic waveform generator: directed corners, then random traffic.
`timescale 1ns / 1ps

module periodic_waveform_generator_unit_tb;
    import pwg_pkg::*;

    localparam int unsigned TABLE_ADDR_BITS = 10;
    localparam int unsigned PHASE_BITS      = 32;
    localparam int unsigned ROM_SIZE        = 1 << TABLE_ADDR_BITS;

    // pi/2 in Q30 for the table build
    localparam longint unsigned QUARTER_TURN_RAD_Q30 = 64'd1686629713;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [MODE_W-1:0] WAVE_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = REG_SAMPLE_COUNT + 1'b1;
    localparam logic [AMP_W-1:0] AMP_FULL = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [COUNT_W-1:0]  number;
        logic                last;
    } tick_sample_t;

    // DUT inputs, known from time zero
    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [31:0]            m_tdata;
    logic                   m_tlast;

    // Shadow of the generator: registers, phase accumulator, block index
    logic [MODE_W-1:0]  cur_wave;
    logic [AMP_W-1:0]   cur_amp;
    logic [31:0]        cur_step;
    logic [31:0]        cur_offset;
    logic [COUNT_W-1:0] cur_count;
    logic [31:0]        gen_phase;
    logic [COUNT_W-1:0] gen_index;
    int                 sine_quarter [0:ROM_SIZE];

    tick_sample_t expected_samples [$];
    int sample_errors = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    periodic_waveform_generator_unit #(
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS),
        .PHASE_BITS     (PHASE_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Quarter-wave sine table, Q1.15, Taylor series in Q30
    function automatic void fill_sine_quarter();
        longint unsigned theta;
        longint unsigned term;
        longint          acc;
        longint          v;
        for (int i = 0; i <= ROM_SIZE; i++) begin
            theta = (QUARTER_TURN_RAD_Q30 * longint'(i)) >> TABLE_ADDR_BITS;
            term  = theta;
            acc   = longint'(theta);
            for (int k = 1; k <= 8; k++) begin
                term = (term * theta) >> 30;
                term = (term * theta) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) acc = 0;
            v = (acc + 64'sd16384) >>> 15;
            if (v > 32768) v = 32768;
            sine_quarter[i] = int'(v);
        end
    endfunction

    // One sample value for the current settings at the given phase
    function automatic logic [SAMPLE_W-1:0] wave_value_at(input logic [31:0] phase);
        longint                     amp_l;
        longint                     mag;
        longint                     res;
        logic [1:0]                 quad;
        logic [TABLE_ADDR_BITS-1:0] w;
        int                         idx;
        amp_l = longint'({49'b0, cur_amp});
        res   = 0;
        case (cur_wave)
            WAVE_SINE: begin
                quad = phase[31:30];
                w    = phase[29 -: TABLE_ADDR_BITS];
                idx  = quad[0] ? int'(ROM_SIZE) - int'(w) : int'(w);
                mag  = (amp_l * longint'(sine_quarter[idx]) + 64'sd16384) >>> 15;
                res  = quad[1] ? -mag : mag;
            end
            WAVE_SQUARE: begin
                if (phase == 32'd0 || phase == HALF_TURN) begin
                    res = 0;
                end else begin
                    res = phase[31] ? -amp_l : amp_l;
                end
            end
            WAVE_SAW: begin
                // floor((amp * (2p - 2^32) + 2^31) / 2^32)
                mag = amp_l * (2 * longint'({32'b0, phase}) - (64'sd1 <<< 32));
                res = (mag + (64'sd1 <<< 31)) >>> 32;
            end
            default: res = 0;
        endcase
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[SAMPLE_W-1:0];
    endfunction

    // Advance the shadow by one tick and queue the sample it produces
    function automatic void predict_tick(input logic restart);
        logic [16:0]  span;
        tick_sample_t s;
        span = (cur_count == 0) ? 17'd1 : {1'b0, cur_count};
        if (restart) begin
            gen_index = '0;
            gen_phase = cur_offset;
        end
        s.last   = ({1'b0, gen_index} >= span - 17'd1);
        s.value  = wave_value_at(gen_phase);
        s.number = gen_index;
        expected_samples.push_back(s);
        if (s.last) begin
            gen_index = '0;
            gen_phase = cur_offset;
        end else begin
            gen_index = gen_index + 1'b1;
            gen_phase = gen_phase + cur_step;
        end
    endfunction

    function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] index,
                                            input logic [31:0] data);
        case (index)
            REG_WAVE_MODE:    cur_wave   = data[MODE_W-1:0];
            REG_AMPLITUDE:    cur_amp    = data[AMP_W-1:0];
            REG_PHASE_STEP:   cur_step   = data;
            REG_PHASE_OFFSET: cur_offset = data;
            REG_SAMPLE_COUNT: cur_count  = data[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Receiver side: random back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Compare each output transaction with the oldest queued sample
    always @(posedge aclk) begin
        tick_sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample value %0d number %0d last %0b",
                         $time, $signed(m_tdata[15:0]), m_tdata[31:16], m_tlast);
                sample_errors++;
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata[15:0] !== want.value) begin
                    $display("%0t: sample_value expected %0d got %0d", $time,
                             $signed(want.value), $signed(m_tdata[15:0]));
                    sample_errors++;
                end
                if (m_tdata[31:16] !== want.number) begin
                    $display("%0t: sample_number expected %0d got %0d", $time,
                             want.number, m_tdata[31:16]);
                    sample_errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last expected %0b got %0b", $time, want.last, m_tlast);
                    sample_errors++;
                end
            end
        end
    end

    // One tick transaction; called and returns at a falling edge
    task automatic send_tick(input logic restart);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tick(restart);
        @(negedge aclk);
    endtask

    // Hold off the sender until every queued sample has come out
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_samples.size() != 0) @(negedge aclk);
    endtask

    // Register write; only issued while the generator is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        apply_reg_write(index, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic program_wave(input logic [MODE_W-1:0] mode, input logic [AMP_W-1:0] amp,
                                input logic [31:0] step, input logic [31:0] offset,
                                input logic [COUNT_W-1:0] count);
        wait_until_drained();
        write_reg(REG_WAVE_MODE, {30'b0, mode});
        write_reg(REG_AMPLITUDE, {17'b0, amp});
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_PHASE_OFFSET, offset);
        write_reg(REG_SAMPLE_COUNT, {16'b0, count});
    endtask

    // Defaults out of reset: sine at phase zero
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
    endtask

    // Quarter-turn steps hit every quadrant and both table ends
    task automatic test_sine_quadrants();
        program_wave(WAVE_SINE, AMP_FULL, QUARTER_TURN, 32'd0, 16'd4);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
    endtask

    // Square is zero exactly at phase zero and half a turn
    task automatic test_square_zero_crossings();
        program_wave(WAVE_SQUARE, AMP_FULL, HALF_TURN, 32'd0, 16'd2);
        send_tick(1'b1);
        send_tick(1'b0);
        program_wave(WAVE_SQUARE, AMP_FULL, 32'd1, 32'hFFFF_FFFF, 16'd3);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
    endtask

    // Sawtooth at both phase ends, zero count, zero amplitude
    task automatic test_sawtooth_extremes();
        program_wave(WAVE_SAW, AMP_FULL, HALF_TURN, 32'd0, 16'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        program_wave(WAVE_SAW, AMP_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        send_tick(1'b1);
        program_wave(WAVE_SAW, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        send_tick(1'b0);
    endtask

    // Unused wave code gives zero; spare register indexes are ignored
    task automatic test_unused_mode_and_spare_regs();
        wait_until_drained();
        write_reg(REG_WAVE_MODE, {30'h3FFF_FFFF, WAVE_UNUSED});
        write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
        for (int unsigned idx = REG_SPARE_FIRST; idx < (1 << CFG_INDEX_W); idx++) begin
            write_reg(idx[CFG_INDEX_W-1:0], $urandom);
        end
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Count shrinks below the running index: flagged last, then wraps
    task automatic test_block_wrap_on_shrink();
        program_wave(WAVE_SINE, AMP_FULL, 32'h0123_4567, 32'h1000_0000, 16'd16);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        wait_until_drained();
        write_reg(REG_SAMPLE_COUNT, 32'd2);
        repeat (3) send_tick(1'b0);
    endtask

    // New random settings between bursts; not every register each time
    task automatic randomize_registers();
        logic [31:0]       data;
        logic [MODE_W-1:0] mode;
        int                pick;
        wait_until_drained();
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            mode = (pick == 0) ? WAVE_UNUSED : MODE_W'(pick % 3);
            data = $urandom;
            data[MODE_W-1:0] = mode;
            write_reg(REG_WAVE_MODE, data);
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            data = $urandom;
            if (pick == 0) data[AMP_W-1:0] = '0;
            if (pick == 1) data[AMP_W-1:0] = AMP_FULL;
            write_reg(REG_AMPLITUDE, data);
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            data = $urandom;
            if (pick == 0) data = 32'd0;
            if (pick == 1) data = 32'hFFFF_FFFF;
            if (pick == 2) data = HALF_TURN;
            write_reg(REG_PHASE_STEP, data);
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            data = $urandom;
            if (pick == 0) data = 32'd0;
            if (pick == 1) data = HALF_TURN;
            write_reg(REG_PHASE_OFFSET, data);
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 19);
            data = $urandom;
            case (pick)
                0:       data[COUNT_W-1:0] = '0;
                1:       data[COUNT_W-1:0] = '1;
                2, 3:    data[COUNT_W-1:0] = 16'd1;
                default: data[COUNT_W-1:0] = 16'($urandom_range(2, 48));
            endcase
            write_reg(REG_SAMPLE_COUNT, data);
        end
        if ($urandom_range(0, 9) == 0) begin
            write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, (1 << CFG_INDEX_W) - 1)),
                      $urandom);
        end
    endtask

    // Bursts of ticks with occasional restarts under the current settings
    task automatic test_random_traffic(input int n_ticks);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_ticks) begin
            randomize_registers();
            burst = $urandom_range(8, 60);
            if (burst > n_ticks - sent) burst = n_ticks - sent;
            repeat (burst) send_tick($urandom_range(0, 19) == 0);
            sent += burst;
        end
    endtask

    initial begin
        fill_sine_quarter();
        cur_wave   = WAVE_SINE;
        cur_amp    = AMP_RESET;
        cur_step   = '0;
        cur_offset = '0;
        cur_count  = COUNT_RESET;
        gen_phase  = '0;
        gen_index  = '0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle_pct  = 35;
        sink_idle_pct = 73;
        test_reset_defaults();
        test_sine_quadrants();
        test_square_zero_crossings();
        test_sawtooth_extremes();
        test_unused_mode_and_spare_regs();
        test_block_wrap_on_shrink();
        test_random_traffic(640);

        src_idle_pct  = 73;
        sink_idle_pct = 35;
        test_random_traffic(640);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(640);

        // Drain, then wait for any stray output
        wait_until_drained();
        repeat (8) @(negedge aclk);
        if (sample_errors == 0 && expected_samples.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
